// ===== rtl/rgpl_pkg.sv =====
package rgpl_pkg;

    // Fixed field widths of the block's payload.
    localparam int COORD_W    = 32;
    localparam int CELL_W     = 18;
    localparam int TOL_W      = 31;
    localparam int COUNT_RAW_W = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Operation codes carried by an input item.
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_LOCATE = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_DIMENSION = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NODES_ON_X     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NODES_ON_Y     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NODES_ON_Z     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE      = 3'd4;

    typedef struct packed {
        logic               operation;
        logic [1:0]         axis;
        logic [5:0]         node_index;
        logic [COORD_W-1:0] node_coord;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [COORD_W-1:0] pos_z;
    } t_in;

    typedef struct packed {
        logic              found;
        logic [CELL_W-1:0] cell_index;
    } t_out;

    // Search status of one axis as a query travels down the chain.
    typedef struct packed {
        logic done;
        logic zero_ok;
    } t_axis_flags;

endpackage

// ===== rtl/rgpl_cell.sv =====
module rgpl_cell #(
    parameter int MAX_NODES  = 64,
    parameter int AXES       = 3,
    parameter int CELL_INDEX = 0
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_wr_en,
    input  logic [1:0]                               i_wr_axis,
    input  logic [5:0]                               i_wr_index,
    input  logic [rgpl_pkg::COORD_W-1:0]             i_wr_coord,
    input  logic [AXES-1:0][$clog2(MAX_NODES+1)-1:0] i_count,
    input  logic [rgpl_pkg::TOL_W-1:0]               i_tol,
    input  logic                                     i_valid,
    input  logic [AXES-1:0][rgpl_pkg::COORD_W-1:0]   i_pos,
    input  rgpl_pkg::t_axis_flags [AXES-1:0]         i_flags,
    input  logic [AXES-1:0][$clog2(MAX_NODES)-1:0]   i_k,
    output logic                                     o_valid,
    output logic [AXES-1:0][rgpl_pkg::COORD_W-1:0]   o_pos,
    output rgpl_pkg::t_axis_flags [AXES-1:0]         o_flags,
    output logic [AXES-1:0][$clog2(MAX_NODES)-1:0]   o_k
);

    localparam int KW = $clog2(MAX_NODES);
    localparam int NW = $clog2(MAX_NODES + 1);
    localparam logic [KW-1:0] MY_K = KW'(CELL_INDEX);
    localparam logic [NW-1:0] MY_N = NW'(CELL_INDEX);

    logic [AXES-1:0][rgpl_pkg::COORD_W-1:0] r_coord;
    logic                                   r_valid;
    logic [AXES-1:0][rgpl_pkg::COORD_W-1:0] r_pos;
    rgpl_pkg::t_axis_flags [AXES-1:0]       r_flags;
    logic [AXES-1:0][KW-1:0]                r_k;
    rgpl_pkg::t_axis_flags [AXES-1:0]       n_flags;
    logic [AXES-1:0][KW-1:0]                n_k;

    // Node store slice: this cell keeps node CELL_INDEX of every axis.
    always_ff @(posedge i_clk) begin
        for (int a = 0; a < AXES; a++) begin
            if (i_wr_en && int'(i_wr_axis) == a && int'(i_wr_index) == CELL_INDEX) begin
                r_coord[a] <= i_wr_coord;
            end
        end
    end

    always_comb begin
        logic                        ge;
        logic                        hit;
        logic [rgpl_pkg::COORD_W:0]  diff;
        for (int a = 0; a < AXES; a++) begin
            ge   = $signed(r_coord[a]) >= $signed(i_pos[a]);
            hit  = !i_flags[a].done && (MY_N < i_count[a]) && ge;
            diff = {r_coord[a][rgpl_pkg::COORD_W-1], r_coord[a]}
                 - {i_pos[a][rgpl_pkg::COORD_W-1], i_pos[a]};
            n_flags[a].done    = i_flags[a].done | hit;
            n_flags[a].zero_ok = i_flags[a].zero_ok;
            if (CELL_INDEX == 0 && hit) begin
                // The first node may admit a point slightly below it.
                n_flags[a].zero_ok = (r_coord[a] == i_pos[a])
                                  || (diff < (rgpl_pkg::COORD_W + 1)'(i_tol));
            end
            n_k[a] = hit ? MY_K : i_k[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos   <= i_pos;
        r_flags <= n_flags;
        r_k     <= n_k;
    end

    assign o_valid = r_valid;
    assign o_pos   = r_pos;
    assign o_flags = r_flags;
    assign o_k     = r_k;

endmodule

// ===== rtl/rgpl_combine.sv =====
module rgpl_combine #(
    parameter int MAX_NODES = 64,
    parameter int AXES      = 3
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    input  rgpl_pkg::t_axis_flags [AXES-1:0]         i_flags,
    input  logic [AXES-1:0][$clog2(MAX_NODES)-1:0]   i_k,
    input  logic [AXES-1:0][$clog2(MAX_NODES+1)-1:0] i_count,
    input  logic [1:0]                               i_dim,
    output logic                                     o_strobe,
    output rgpl_pkg::t_out                           o_result
);

    localparam int CW = rgpl_pkg::CELL_W;

    logic [2:0]          w_ok;
    logic [2:0][CW-1:0]  w_cell;
    logic [1:0][CW-1:0]  w_span;
    logic                w_found;
    logic [2*CW-1:0]     w_prod_a;
    logic [2*CW-1:0]     w_prod_b;

    logic                r_a_valid;
    logic                r_a_found;
    logic [CW-1:0]       r_a_cx;
    logic [CW-1:0]       r_a_span;
    logic [CW-1:0]       r_a_h;
    logic                r_strobe;
    rgpl_pkg::t_out      r_result;

    for (genvar ga = 0; ga < 3; ga++) begin : g_axis
        if (ga < AXES) begin : g_used
            logic w_in_use;
            assign w_in_use = ga < int'(i_dim);
            assign w_ok[ga] = !w_in_use || (i_flags[ga].done
                            && (i_k[ga] != '0 || i_flags[ga].zero_ok));
            assign w_cell[ga] = (!w_in_use || i_k[ga] == '0) ? '0
                              : CW'(i_k[ga]) - CW'(1);
            if (ga < 2) begin : g_span
                assign w_span[ga] = CW'(i_count[ga]) - CW'(1);
            end
        end else begin : g_absent
            assign w_ok[ga]   = 1'b1;
            assign w_cell[ga] = '0;
            if (ga < 2) begin : g_span
                assign w_span[ga] = '0;
            end
        end
    end

    assign w_found  = &w_ok;
    // Horner form: index = cx + span_x * (cy + span_y * cz), kept to 18 bits.
    assign w_prod_a = w_span[1] * w_cell[2];
    assign w_prod_b = r_a_span * r_a_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_strobe  <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_found           <= w_found;
        r_a_cx              <= w_cell[0];
        r_a_span            <= w_span[0];
        r_a_h               <= w_cell[1] + w_prod_a[CW-1:0];
        r_result.found      <= r_a_found;
        r_result.cell_index <= r_a_found ? (r_a_cx + w_prod_b[CW-1:0]) : '0;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ===== rtl/rectilinear_grid_point_locate.sv =====
// Rectilinear grid point locator. An item is taken at a rising edge with start high and busy
// low. A load item writes one node coordinate in that cycle and gives no result, so busy
// stays low and another item can follow at once. A locate item raises busy while the query
// walks the chain of node cells, one cell per cycle, and busy falls once the query leaves
// the last cell; no new item is taken before then. Its result appears on o_result with
// o_strobe high for a single cycle, after the query has passed the combine stage.
// The receiver cannot stall: a result must be captured in the cycle its strobe is high.
// Configuration writes are always ready and must be issued only while no query is in
// flight. Node coordinates are undefined until loaded.
module rectilinear_grid_point_locate #(
    parameter int MAX_NODES = 64,
    parameter int AXES      = 3
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  rgpl_pkg::t_in                     i_item,
    output logic                              o_strobe,
    output rgpl_pkg::t_out                    o_result,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rgpl_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rgpl_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int KW = $clog2(MAX_NODES);
    localparam int NW = $clog2(MAX_NODES + 1);
    localparam int RW = rgpl_pkg::COUNT_RAW_W;

    // Configuration registers.
    logic [1:0]                  r_dim;
    logic [RW-1:0]               r_nx;
    logic [RW-1:0]               r_ny;
    logic [RW-1:0]               r_nz;
    logic [rgpl_pkg::TOL_W-1:0]  r_tol;
    logic                        r_busy;

    logic                        w_take;
    logic                        w_load;
    logic                        w_query;
    logic [2:0][RW-1:0]          w_raw_count;
    logic [2:0][rgpl_pkg::COORD_W-1:0] w_pos3;
    logic [AXES-1:0][NW-1:0]     w_count;
    logic [1:0]                  w_dim;

    // The chain: stage 0 is the query entering, stage MAX_NODES leaves the last cell.
    logic                                   w_valid [MAX_NODES+1];
    logic [AXES-1:0][rgpl_pkg::COORD_W-1:0] w_pos   [MAX_NODES+1];
    rgpl_pkg::t_axis_flags [AXES-1:0]       w_flags [MAX_NODES+1];
    logic [AXES-1:0][KW-1:0]                w_k     [MAX_NODES+1];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim <= 2'd3;
            r_nx  <= RW'(2);
            r_ny  <= RW'(2);
            r_nz  <= RW'(2);
            r_tol <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rgpl_pkg::CFG_GRID_DIMENSION: r_dim <= i_cfg_data[1:0];
                rgpl_pkg::CFG_NODES_ON_X:     r_nx  <= i_cfg_data[RW-1:0];
                rgpl_pkg::CFG_NODES_ON_Y:     r_ny  <= i_cfg_data[RW-1:0];
                rgpl_pkg::CFG_NODES_ON_Z:     r_nz  <= i_cfg_data[RW-1:0];
                rgpl_pkg::CFG_TOLERANCE:      r_tol <= i_cfg_data[rgpl_pkg::TOL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Node counts are held between two and MAX_NODES; dimension between one and AXES.
    assign w_raw_count = {r_nz, r_ny, r_nx};

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            if (w_raw_count[a] < RW'(2)) begin
                w_count[a] = NW'(2);
            end else if (int'(w_raw_count[a]) > MAX_NODES) begin
                w_count[a] = NW'(MAX_NODES);
            end else begin
                w_count[a] = NW'(w_raw_count[a]);
            end
        end
        if (r_dim == 2'd0) begin
            w_dim = 2'd1;
        end else if (int'(r_dim) > AXES) begin
            w_dim = 2'(AXES);
        end else begin
            w_dim = r_dim;
        end
    end

    // Item acceptance. A load is written straight into the matching cell; a query
    // enters the head of the chain and holds busy until it leaves the last cell.
    assign w_take  = start && !r_busy;
    assign w_load  = w_take && (i_item.operation == rgpl_pkg::OP_LOAD)
                  && (int'(i_item.axis) < AXES);
    assign w_query = w_take && (i_item.operation == rgpl_pkg::OP_LOCATE);
    assign busy    = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_query) begin
            r_busy <= 1'b1;
        end else if (w_valid[MAX_NODES]) begin
            r_busy <= 1'b0;
        end
    end

    assign w_pos3 = {i_item.pos_z, i_item.pos_y, i_item.pos_x};

    assign w_valid[0] = w_query;
    assign w_pos[0]   = w_pos3[AXES-1:0];
    assign w_flags[0] = '0;
    assign w_k[0]     = '0;

    // Each cell compares its stored nodes with the passing query and marks the
    // first node at or above the point on each axis.
    for (genvar gi = 0; gi < MAX_NODES; gi++) begin : g_cell
        rgpl_cell #(
            .MAX_NODES  (MAX_NODES),
            .AXES       (AXES),
            .CELL_INDEX (gi)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_wr_en    (w_load),
            .i_wr_axis  (i_item.axis),
            .i_wr_index (i_item.node_index),
            .i_wr_coord (i_item.node_coord),
            .i_count    (w_count),
            .i_tol      (r_tol),
            .i_valid    (w_valid[gi]),
            .i_pos      (w_pos[gi]),
            .i_flags    (w_flags[gi]),
            .i_k        (w_k[gi]),
            .o_valid    (w_valid[gi+1]),
            .o_pos      (w_pos[gi+1]),
            .o_flags    (w_flags[gi+1]),
            .o_k        (w_k[gi+1])
        );
    end

    // The per-axis cells are checked and folded into one linear index, x fastest,
    // over two registered multiply stages.
    rgpl_combine #(
        .MAX_NODES (MAX_NODES),
        .AXES      (AXES)
    ) u_combine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_valid[MAX_NODES]),
        .i_flags  (w_flags[MAX_NODES]),
        .i_k      (w_k[MAX_NODES]),
        .i_count  (w_count),
        .i_dim    (w_dim),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

// ===== tb/rgpl_cell_check.sv =====
module rgpl_cell_check #(
    parameter int MAX_NODES = 64,
    parameter int AXES      = 3
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic                            i_busy,
    input  rgpl_pkg::t_in                   i_item,
    input  logic                            i_strobe,
    input  rgpl_pkg::t_out                  i_result,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [rgpl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rgpl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    import rgpl_pkg::*;

    // Private copy of the node store and the register file.
    logic signed [COORD_W-1:0] node_coord [AXES][MAX_NODES];
    logic [1:0]                dim_reg;
    logic [COUNT_RAW_W-1:0]    count_reg [3];
    logic [TOL_W-1:0]          tol_reg;
    t_out                      expected_cells [$];
    t_out                      oldest;
    int                        fails = 0;

    function automatic int unsigned used_span(input logic [COUNT_RAW_W-1:0] raw);
        if (raw < 2)
            return 2;
        if (raw > MAX_NODES)
            return MAX_NODES;
        return raw;
    endfunction

    // Per axis: the first node at or above the point picks the cell; a point
    // under the first node only passes when it is equal or within tolerance.
    function automatic t_out locate_point(input t_in q);
        t_out                      answer;
        logic signed [COORD_W-1:0] coord [3];
        int unsigned               axes_used;
        int unsigned               span;
        int unsigned               hit;
        longint                    gap;
        longint unsigned           linear;
        longint unsigned           stride;
        answer    = '0;
        coord[0]  = q.pos_x;
        coord[1]  = q.pos_y;
        coord[2]  = q.pos_z;
        axes_used = (dim_reg == 2'd0) ? 1 : dim_reg;
        if (axes_used > AXES)
            axes_used = AXES;
        linear = 0;
        stride = 1;
        for (int ax = 0; ax < axes_used; ax++) begin
            span = used_span(count_reg[ax]);
            hit  = span;
            for (int k = span - 1; k >= 0; k--) begin
                if (node_coord[ax][k] >= coord[ax])
                    hit = k;
            end
            if (hit == span)
                return '0;
            if (hit == 0) begin
                gap = longint'(node_coord[ax][0]) - longint'(coord[ax]);
                if (gap != 0 && gap >= longint'(tol_reg))
                    return '0;
            end else begin
                linear += stride * (hit - 1);
            end
            stride *= span - 1;
        end
        answer.found      = 1'b1;
        answer.cell_index = linear[CELL_W-1:0];
        return answer;
    endfunction

    task automatic note_fault(input string what, input t_out want, input t_out got);
        if (fails < 10)
            $display("cell lookup %s: expected found=%0b cell=%0d, got found=%0b cell=%0d",
                     what, want.found, want.cell_index, got.found, got.cell_index);
        fails++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dim_reg      = 2'd3;
            count_reg[0] = 7'd2;
            count_reg[1] = 7'd2;
            count_reg[2] = 7'd2;
            tol_reg      = '0;
            expected_cells.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_GRID_DIMENSION: dim_reg      = i_cfg_data[1:0];
                    CFG_NODES_ON_X:     count_reg[0] = i_cfg_data[COUNT_RAW_W-1:0];
                    CFG_NODES_ON_Y:     count_reg[1] = i_cfg_data[COUNT_RAW_W-1:0];
                    CFG_NODES_ON_Z:     count_reg[2] = i_cfg_data[COUNT_RAW_W-1:0];
                    CFG_TOLERANCE:      tol_reg      = i_cfg_data[TOL_W-1:0];
                    default: ;
                endcase
            end
            // A result leaving now belongs to an earlier query, so it is
            // checked before a query taken at this edge is queued.
            if (i_strobe) begin
                if (expected_cells.size() == 0) begin
                    note_fault("result with nothing outstanding", '0, i_result);
                end else begin
                    oldest = expected_cells.pop_front();
                    if (i_result.found !== oldest.found ||
                        i_result.cell_index !== oldest.cell_index)
                        note_fault("mismatch", oldest, i_result);
                end
            end
            if (i_start && !i_busy) begin
                if (i_item.operation == OP_LOCATE)
                    expected_cells.insert(expected_cells.size(), locate_point(i_item));
                else if (i_item.axis < AXES && i_item.node_index < MAX_NODES)
                    node_coord[i_item.axis][i_item.node_index] = i_item.node_coord;
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_cells.size();
    end

endmodule

// ===== tb/rectilinear_grid_point_locate_test.sv =====
module rectilinear_grid_point_locate_test;
    import rgpl_pkg::*;

    localparam int MAX_NODES     = 64;
    localparam int AXES          = 3;
    localparam int N_REGS        = CFG_TOLERANCE + 1;
    localparam int LAST_REG_IDX  = (1 << CFG_IDX_W) - 1;
    localparam int RANDOM_ITEMS  = 650;
    // A query holds the block while it walks the chain and its result shows up
    // after the combine stage, so this covers the tail.
    localparam int SETTLE_CYCLES = MAX_NODES + 8;
    // The slowest correct run is roughly 1200 transactions, each with a query
    // in flight and the longest sender gap, plus the settle time between
    // phases. The limit is several times that.
    localparam int CYCLE_LIMIT   = 1_000_000;

    localparam longint             C_LO      = -64'sd2147483648;
    localparam longint             C_HI      = 64'sd2147483647;
    localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;
    localparam logic [COORD_W-1:0] COORD_MAX = 32'h7FFF_FFFF;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  start       = 1'b0;
    logic                  busy;
    t_in                   i_item      = '0;
    logic                  o_strobe;
    t_out                  o_result;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    int fail_count;
    int pending;
    int cycle_count  = 0;
    int random_items = 0;

    // Stimulus-side bookkeeping: the coordinates loaded so far and the
    // effective grid shape, used only to aim query points at useful places.
    longint      grid [AXES][MAX_NODES];
    int unsigned used_dim;
    int unsigned used_count [AXES];
    int unsigned tol_now;
    bit          burst;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    rectilinear_grid_point_locate #(
        .MAX_NODES(MAX_NODES),
        .AXES     (AXES)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    rgpl_cell_check #(
        .MAX_NODES(MAX_NODES),
        .AXES     (AXES)
    ) u_cell_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_item      (i_item),
        .i_strobe    (o_strobe),
        .i_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Mostly back-to-back, sometimes a short gap, now and then a pause that can
    // outlast a whole query walk. Burst phases never pause.
    function automatic int unsigned idle_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (burst || roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 96)
            return $urandom_range(4, 16);
        return $urandom_range(30, 130);
    endfunction

    // The load fields are don't-care on a query and the point fields on a
    // load; both get random values so every bit moves.
    function automatic t_in make_locate(input logic [COORD_W-1:0] x, y, z);
        t_in it;
        it.operation  = OP_LOCATE;
        it.axis       = 2'($urandom);
        it.node_index = 6'($urandom);
        it.node_coord = $urandom;
        it.pos_x      = x;
        it.pos_y      = y;
        it.pos_z      = z;
        return it;
    endfunction

    function automatic t_in make_load(input int ax, input int idx,
                                      input logic [COORD_W-1:0] coord);
        t_in it;
        it.operation  = OP_LOAD;
        it.axis       = 2'(ax);
        it.node_index = 6'(idx);
        it.node_coord = coord;
        it.pos_x      = $urandom;
        it.pos_y      = $urandom;
        it.pos_z      = $urandom;
        return it;
    endfunction

    // Picks one coordinate of a query point against the loaded nodes of an
    // axis: mostly inside a cell, plus node hits, the slack zone under the
    // first node, its exact edge, beyond the last node and the range limits.
    function automatic logic [COORD_W-1:0] pick_point(input int ax);
        longint      p;
        longint      lo;
        longint      hi;
        int unsigned n;
        int unsigned k;
        int unsigned roll;
        n    = used_count[ax];
        roll = $urandom_range(0, 15);
        k    = $urandom_range(1, n - 1);
        lo   = grid[ax][k - 1];
        hi   = grid[ax][k];
        if (roll < 9)
            p = (hi > lo) ? lo + 1 + longint'($urandom) % (hi - lo) : hi;
        else if (roll == 9)
            p = grid[ax][$urandom_range(0, n - 1)];
        else if (roll == 10)
            p = grid[ax][0] - ((tol_now == 0) ? 0 : longint'($urandom) % longint'(tol_now));
        else if (roll == 11)
            p = grid[ax][0] - longint'(tol_now);
        else if (roll == 12)
            p = grid[ax][n - 1] + 1 + longint'($urandom_range(0, 1 << 17));
        else if (roll == 13)
            p = C_LO;
        else if (roll == 14)
            p = C_HI;
        else
            p = longint'(signed'($urandom));
        if (p < C_LO)
            p = C_LO;
        if (p > C_HI)
            p = C_HI;
        return p[COORD_W-1:0];
    endfunction

    // Offers one item and returns at the edge that takes the transaction.
    // start stays high so a following item can go out with no gap; it is only
    // lowered when an idle stretch comes first or when settle() runs.
    task automatic send_item(input t_in it);
        int unsigned gap;
        gap = idle_len();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        if (it.operation == OP_LOAD && it.axis < AXES)
            grid[it.axis][it.node_index] = longint'(signed'(it.node_coord));
    endtask

    // Same pattern on the configuration channel: valid is dropped by the
    // caller once the last register of a batch is written.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        int unsigned gap;
        gap = idle_len();
        if (gap > 0) begin
            i_cfg_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Lets every outstanding query come back, then waits out the walk of the
    // chain so that the block is idle before registers change.
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Loads every used node of one axis, ascending or descending in index.
    // Most grids rise strictly; some repeat coordinates and a few are not
    // sorted at all.
    task automatic load_axis(input int ax);
        longint      nodes [MAX_NODES];
        longint      v;
        longint      step_min;
        longint      step_max;
        int unsigned n;
        int unsigned shape;
        int          k;
        bit          falling_order;
        n             = used_count[ax];
        shape         = $urandom_range(0, 9);
        falling_order = $urandom_range(0, 1);
        step_min      = 1;
        if (shape < 5) begin
            v        = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
            step_max = 200000;
        end else if (shape < 8) begin
            // Spread over the whole signed range.
            v        = C_LO + longint'($urandom_range(0, 1 << 20));
            step_max = (64'sd4294967295 - (1 << 20)) / longint'(n);
        end else begin
            v        = longint'($urandom_range(0, 1 << 24)) - (1 << 23);
            step_min = 0;
            step_max = 3;
        end
        for (int i = 0; i < n; i++) begin
            nodes[i] = (shape == 9) ? longint'(signed'($urandom)) : v;
            v += step_min + longint'($urandom) % (step_max - step_min + 1);
        end
        for (int i = 0; i < n; i++) begin
            k = falling_order ? n - 1 - i : i;
            send_item(make_load(ax, k, nodes[k][COORD_W-1:0]));
            random_items++;
        end
    endtask

    // One random phase: a fresh register setting, a freshly loaded grid, then
    // a run of queries with a few reloads and stray loads mixed in.
    task automatic run_phase(input bit full_size);
        logic [CFG_DATA_W-1:0]  regs [N_REGS];
        logic [COUNT_RAW_W-1:0] raw;
        logic [1:0]             dim;
        longint                 lo;
        longint                 hi;
        int unsigned            first;
        int unsigned            roll;
        int unsigned            n_ops;
        int                     ax;
        int                     k;
        t_in                    it;

        // Upper data bits beyond each register's width are random garbage.
        dim = full_size ? 2'd3 : 2'($urandom_range(0, 3));
        regs[CFG_GRID_DIMENSION]       = $urandom;
        regs[CFG_GRID_DIMENSION][1:0]  = dim;
        used_dim = (dim == 2'd0) ? 1 : dim;
        for (int a = 0; a < AXES; a++) begin
            roll = $urandom_range(0, 23);
            if (full_size || roll == 1)
                raw = COUNT_RAW_W'($urandom_range(MAX_NODES, 127));
            else if (roll == 0)
                raw = COUNT_RAW_W'($urandom_range(0, 1));
            else if (roll < 5)
                raw = COUNT_RAW_W'($urandom_range(10, MAX_NODES - 1));
            else
                raw = COUNT_RAW_W'($urandom_range(2, 8));
            regs[CFG_NODES_ON_X + a]                = $urandom;
            regs[CFG_NODES_ON_X + a][COUNT_RAW_W-1:0] = raw;
            used_count[a] = (raw < 2) ? 2 : (raw > MAX_NODES) ? MAX_NODES : raw;
        end
        roll = $urandom_range(0, 7);
        if (roll == 0)
            tol_now = 0;
        else if (roll == 1)
            tol_now = 32'h7FFF_FFFF;
        else if (roll < 6)
            tol_now = $urandom_range(0, 32'h0003_0000);
        else
            tol_now = $urandom & 32'h7FFF_FFFF;
        regs[CFG_TOLERANCE] = {1'($urandom_range(0, 1)), tol_now[TOL_W-1:0]};

        first = $urandom_range(0, N_REGS - 1);
        for (int i = 0; i < N_REGS; i++)
            write_reg(CFG_IDX_W'((first + i) % N_REGS), regs[(first + i) % N_REGS]);
        // Indexes past the register file are accepted and ignored.
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_IDX_W'($urandom_range(N_REGS, LAST_REG_IDX)), $urandom);
        i_cfg_valid <= 1'b0;

        burst = ($urandom_range(0, 3) == 0);
        for (int a = 0; a < used_dim; a++)
            load_axis(a);

        n_ops = $urandom_range(12, 32);
        for (int i = 0; i < n_ops; i++) begin
            roll = $urandom_range(0, 19);
            if (roll < 16) begin
                it = make_locate(pick_point(0), pick_point(1), pick_point(2));
            end else if (roll < 18) begin
                // Reload a used node, either between its neighbours or anywhere.
                ax = $urandom_range(0, used_dim - 1);
                k  = $urandom_range(0, used_count[ax] - 1);
                lo = (k > 0) ? grid[ax][k - 1] : C_LO;
                hi = (k < used_count[ax] - 1) ? grid[ax][k + 1] : C_HI;
                if (roll == 16 && hi >= lo)
                    it = make_load(ax, k, COORD_W'(lo + longint'($urandom) % (hi - lo + 1)));
                else
                    it = make_load(ax, k, $urandom);
            end else if (roll == 18) begin
                // No such axis: the block drops this one.
                it = make_load(3, $urandom_range(0, MAX_NODES - 1), $urandom);
            end else begin
                it = make_load($urandom_range(0, AXES - 1), $urandom_range(0, MAX_NODES - 1),
                               $urandom);
            end
            send_item(it);
            if (!(it.operation == OP_LOAD && it.axis >= AXES))
                random_items++;
        end
        settle();
    endtask

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        burst = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: a 2x2x2 grid whose x axis spans the whole signed range,
        // with a slack of 1.0 below the first node. Counts below two act as two.
        write_reg(CFG_TOLERANCE, 32'h0001_0000);
        write_reg(CFG_GRID_DIMENSION, 32'd3);
        write_reg(CFG_NODES_ON_X, 32'd2);
        write_reg(CFG_NODES_ON_Y, 32'd1);
        write_reg(CFG_NODES_ON_Z, 32'd0);
        i_cfg_valid <= 1'b0;
        send_item(make_load(0, 0, COORD_MIN));
        send_item(make_load(0, 1, COORD_MAX));
        send_item(make_load(1, 0, 32'h0000_0000));
        send_item(make_load(1, 1, 32'h0001_0000));
        send_item(make_load(2, 0, 32'h0001_0000));
        send_item(make_load(2, 1, 32'h0002_0000));
        send_item(make_load(2, MAX_NODES - 1, $urandom));
        // A load to a nonexistent axis must leave the store alone.
        send_item(make_load(3, MAX_NODES - 1, 32'hDEAD_BEEF));
        // Points on the first and last nodes, then inside.
        send_item(make_locate(COORD_MIN, 32'h0000_0000, 32'h0002_0000));
        send_item(make_locate(COORD_MAX, 32'h0000_8000, 32'h0001_8000));
        // Half a unit under the first y node is within the slack.
        send_item(make_locate(32'h0000_0000, 32'hFFFF_8000, 32'h0001_0000));
        // Exactly one unit under is not.
        send_item(make_locate(32'h0000_0000, 32'hFFFF_0000, 32'h0001_0000));
        // Just above the last y node, then far below the first z node.
        send_item(make_locate(32'h0000_0000, 32'h0001_0001, 32'h0001_0000));
        send_item(make_locate(32'h0000_0000, 32'h0000_0000, COORD_MIN));
        settle();

        // Dimension zero acts as one axis; the largest slack.
        write_reg(CFG_GRID_DIMENSION, 32'd0);
        write_reg(CFG_TOLERANCE, 32'h7FFF_FFFF);
        i_cfg_valid <= 1'b0;
        send_item(make_locate(COORD_MIN, $urandom, $urandom));
        send_item(make_load(0, 0, 32'h7FFF_FFFE));
        // Gap of nearly 2**32 is beyond any slack; a gap under it is not.
        send_item(make_locate(COORD_MIN, $urandom, $urandom));
        send_item(make_locate(32'h0000_0000, $urandom, $urandom));
        send_item(make_locate(COORD_MAX, $urandom, $urandom));
        settle();

        // Random part: one phase with the largest grid, then smaller ones.
        run_phase(1'b1);
        while (random_items < RANDOM_ITEMS)
            run_phase(1'b0);

        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/rgpl_pkg.sv
rtl/rgpl_cell.sv
rtl/rgpl_combine.sv
rtl/rectilinear_grid_point_locate.sv
tb/rgpl_cell_check.sv
tb/rectilinear_grid_point_locate_test.sv
